@@ rtl/core/tpsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tpsp_pkg;

   localparam int STEPS      = 100;
   localparam int ROM_LEN    = 3 * STEPS;
   localparam int HALF_LEN   = ROM_LEN / 2 + 1;
   localparam int STEP_W     = $clog2(STEPS);
   localparam int IDX_W      = $clog2(ROM_LEN);
   localparam int HALF_W     = $clog2(HALF_LEN);
   localparam int OUT_STEP_W = 7;
   localparam int DATA_W     = 16;
   localparam int PHASES     = 3;
   localparam int PHASE_W    = $clog2(PHASES);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int MUL_A_W    = 30;
   localparam int MUL_B_W    = 16;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int MAG_W      = 15;

   localparam logic [DATA_W-1:0] AMPLITUDE_RESET = 16'd21299;
   localparam logic [DATA_W-1:0] PERIOD_RESET    = 16'd1000;
   localparam logic [DATA_W-1:0] DIVIDER_RESET   = 16'd10;

   localparam logic [63:0] ROM_LEN64 = 64'(ROM_LEN);
   localparam logic [63:0] Q30_ONE   = 64'd1073741824;
   localparam logic [63:0] Q30_PI4   = 64'd843314857;

   typedef enum logic [1:0] {
      CSR_AMPLITUDE = 2'd0,
      CSR_PERIOD    = 2'd1,
      CSR_DIVIDER   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] amplitude_q15;
      logic [DATA_W-1:0] pwm_period;
      logic [DATA_W-1:0] tick_divider;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOOKUP,
      BK_SCALE,
      BK_PERIOD,
      BK_DONE
   } bk_state_type;

   typedef logic signed [DATA_W-1:0] cos_half_type [HALF_LEN];

   function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> 30;
   endfunction

   function automatic logic [63:0] taylor_q30(input logic [63:0] theta, input logic want_sin);
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] sum;
      t2   = mul_q30(theta, theta);
      term = want_sin ? theta : Q30_ONE;
      sum  = term;
      for (int k = 1; k <= 4; k++) begin
         term = mul_q30(term, t2);
         case (k)
            1:       term = want_sin ? term / 6  : term / 2;
            2:       term = want_sin ? term / 20 : term / 12;
            3:       term = want_sin ? term / 42 : term / 30;
            default: term = want_sin ? term / 72 : term / 56;
         endcase
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic logic signed [DATA_W-1:0] rom_entry(input int j);
      logic [63:0] t;
      logic [63:0] oct;
      logic [63:0] rem;
      logic [63:0] theta;
      logic [63:0] v;
      logic        use_sin;
      logic        neg;
      t   = 64'(j) * 64'd8;
      oct = (t / ROM_LEN64) & 64'd7;
      rem = t % ROM_LEN64;
      if (oct[0]) begin
         rem = ROM_LEN64 - rem;
      end
      theta   = rem * Q30_PI4 / ROM_LEN64;
      use_sin = (oct == 64'd1) || (oct == 64'd2) || (oct == 64'd5) || (oct == 64'd6);
      neg     = (oct >= 64'd2) && (oct <= 64'd5);
      v = taylor_q30(theta, use_sin);
      v = (v + 64'd16384) >> 15;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return neg ? -DATA_W'(v) : DATA_W'(v);
   endfunction

   // The cosine is even over a turn, so entry j and entry ROM_LEN-j are equal;
   // only the first half of the turn is kept.
   function automatic cos_half_type build_cos_half();
      cos_half_type tab;
      for (int j = 0; j < HALF_LEN; j++) begin
         tab[j] = rom_entry(j);
      end
      return tab;
   endfunction

   localparam cos_half_type COS_HALF = build_cos_half();

endpackage

`default_nettype wire

@@ rtl/core/three_phase_sine_pwm_generator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three-phase sine PWM generator. A req_ transaction with req_tick_pulse set is
// one timer tick; the tick counter picks one tick in tick_divider and that tick
// yields one rsp_ transaction with the three compare values, the three direction
// bits and the step of the turn that was used, after which the step moves on by
// one. Ticks are taken in one cycle each as long as the two-entry queue of pending
// updates has room. The back end pops an update, works through each phase as
// table read, amplitude product and period product on the one shared 30 x 16
// bit multiplier, and loads the output register once it is free; that register
// holds the result while the back end moves on to the next update. Writes on the
// csr_ port are taken in every cycle and are meant for when the block is idle.
module three_phase_sine_pwm_generator_unit
   import tpsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [DATA_W-1:0]     csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_tick_pulse,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_W-1:0]     rsp_duty_a,
   output logic [DATA_W-1:0]     rsp_duty_b,
   output logic [DATA_W-1:0]     rsp_duty_c,
   output logic                  rsp_dir_a,
   output logic                  rsp_dir_b,
   output logic                  rsp_dir_c,
   output logic [OUT_STEP_W-1:0] rsp_step_used
);

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic              q_push;
   logic [STEP_W-1:0] q_push_step;
   logic              q_push_ready;
   logic              q_pop;
   logic              q_pop_valid;
   logic [STEP_W-1:0] q_pop_step;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AMPLITUDE: cfg_in.amplitude_q15 = csr_wdata;
            CSR_PERIOD:    cfg_in.pwm_period    = csr_wdata;
            CSR_DIVIDER:   cfg_in.tick_divider  = csr_wdata;
            default:       cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.amplitude_q15 <= AMPLITUDE_RESET;
         cfg_ff.pwm_period    <= PERIOD_RESET;
         cfg_ff.tick_divider  <= DIVIDER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpsp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_tick_pulse (req_tick_pulse),
      .q_ready        (q_push_ready),
      .q_push         (q_push),
      .q_step         (q_push_step)
   );

   tpsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_step  (q_push_step),
      .push_ready (q_push_ready),
      .pop        (q_pop),
      .pop_valid  (q_pop_valid),
      .pop_step   (q_pop_step)
   );

   tpsp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_valid       (q_pop_valid),
      .q_step        (q_pop_step),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_duty_a    (rsp_duty_a),
      .rsp_duty_b    (rsp_duty_b),
      .rsp_duty_c    (rsp_duty_c),
      .rsp_dir_a     (rsp_dir_a),
      .rsp_dir_b     (rsp_dir_b),
      .rsp_dir_c     (rsp_dir_c),
      .rsp_step_used (rsp_step_used)
   );

endmodule

`default_nettype wire

@@ rtl/core/tpsp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpsp_front
   import tpsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_tick_pulse,
   input  logic              q_ready,
   output logic              q_push,
   output logic [STEP_W-1:0] q_step
);

   logic [DATA_W-1:0] tick_count_ff;
   logic [DATA_W-1:0] tick_count_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              accept;
   logic              tick;
   logic [DATA_W-1:0] div_eff;
   logic [DATA_W:0]   count_inc;

   assign req_ready = q_ready;
   assign accept    = req_valid && req_ready;
   assign tick      = accept && req_tick_pulse;
   assign q_push    = tick && (tick_count_ff == '0);
   assign q_step    = step_ff;

   always_comb begin
      div_eff   = (cfg.tick_divider == '0) ? DATA_W'(1) : cfg.tick_divider;
      count_inc = (DATA_W + 1)'(tick_count_ff) + (DATA_W + 1)'(1);
      tick_count_in = tick_count_ff;
      step_in       = step_ff;
      if (tick) begin
         tick_count_in = (count_inc >= (DATA_W + 1)'(div_eff)) ? '0 : count_inc[DATA_W-1:0];
      end
      if (q_push) begin
         step_in = (step_ff == STEP_W'(STEPS - 1)) ? '0 : step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         step_ff       <= '0;
      end else begin
         tick_count_ff <= tick_count_in;
         step_ff       <= step_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tpsp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpsp_queue
   import tpsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [STEP_W-1:0] push_step,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output logic [STEP_W-1:0] pop_step
);

   logic [STEP_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_step   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tpsp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpsp_back
   import tpsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  logic [STEP_W-1:0]     q_step,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_W-1:0]     rsp_duty_a,
   output logic [DATA_W-1:0]     rsp_duty_b,
   output logic [DATA_W-1:0]     rsp_duty_c,
   output logic                  rsp_dir_a,
   output logic                  rsp_dir_b,
   output logic                  rsp_dir_c,
   output logic [OUT_STEP_W-1:0] rsp_step_used
);

   bk_state_type state_ff;
   bk_state_type state_in;

   logic [STEP_W-1:0]     step_ff;
   logic [STEP_W-1:0]     step_in;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   logic [PHASE_W-1:0]    phase_ff;
   logic [PHASE_W-1:0]    phase_in;
   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic [PROD_W-1:0]     prod_ff;
   logic [PROD_W-1:0]     prod_in;
   logic [DATA_W-1:0]     duty_ff [PHASES];
   logic [DATA_W-1:0]     duty_in [PHASES];
   logic                  dir_ff  [PHASES];
   logic                  dir_in  [PHASES];

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_W-1:0]     rsp_duty_a_ff;
   logic [DATA_W-1:0]     rsp_duty_a_in;
   logic [DATA_W-1:0]     rsp_duty_b_ff;
   logic [DATA_W-1:0]     rsp_duty_b_in;
   logic [DATA_W-1:0]     rsp_duty_c_ff;
   logic [DATA_W-1:0]     rsp_duty_c_in;
   logic                  rsp_dir_a_ff;
   logic                  rsp_dir_a_in;
   logic                  rsp_dir_b_ff;
   logic                  rsp_dir_b_in;
   logic                  rsp_dir_c_ff;
   logic                  rsp_dir_c_in;
   logic [OUT_STEP_W-1:0] rsp_step_ff;
   logic [OUT_STEP_W-1:0] rsp_step_in;

   logic                  out_free;
   logic                  load_out;
   logic                  do_lookup;
   logic                  do_scale;
   logic                  do_period;
   logic                  last_phase;
   logic [HALF_W-1:0]     fold_idx;
   logic [IDX_W:0]        idx_next;
   logic [DATA_W-1:0]     entry_abs;
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [PROD_W-1:0]     mul_out;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_phase = (phase_ff == PHASE_W'(PHASES - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               state_in = BK_LOOKUP;
            end
         end
         BK_LOOKUP: state_in = BK_SCALE;
         BK_SCALE:  state_in = BK_PERIOD;
         BK_PERIOD: state_in = last_phase ? BK_DONE : BK_LOOKUP;
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      do_lookup = 1'b0;
      do_scale  = 1'b0;
      do_period = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         BK_IDLE:   q_pop     = q_valid;
         BK_LOOKUP: do_lookup = 1'b1;
         BK_SCALE:  do_scale  = 1'b1;
         BK_PERIOD: do_period = 1'b1;
         BK_DONE:   load_out  = out_free;
         default:   q_pop     = 1'b0;
      endcase
   end

   // One multiplier serves both products of a phase: amplitude times the
   // cosine magnitude, then the fraction below one times the period. The
   // whole part of the first product is what the modulo by the period removes.
   always_comb begin
      fold_idx  = (idx_ff < IDX_W'(HALF_LEN)) ? HALF_W'(idx_ff)
                                              : HALF_W'(IDX_W'(ROM_LEN) - idx_ff);
      idx_next  = (IDX_W + 1)'(idx_ff) + (IDX_W + 1)'(STEPS);
      entry_abs = entry_ff[DATA_W-1] ? DATA_W'(-entry_ff) : DATA_W'(entry_ff);
      if (do_scale) begin
         mul_a = MUL_A_W'(entry_abs[MAG_W-1:0]);
         mul_b = cfg.amplitude_q15;
      end else begin
         mul_a = prod_ff[MUL_A_W-1:0];
         mul_b = cfg.pwm_period;
      end
      mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      step_in  = step_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      entry_in = entry_ff;
      prod_in  = prod_ff;
      duty_in  = duty_ff;
      dir_in   = dir_ff;
      if (q_pop) begin
         step_in  = q_step;
         idx_in   = IDX_W'(q_step) + IDX_W'(q_step) + IDX_W'(q_step);
         phase_in = '0;
      end
      if (do_lookup) begin
         entry_in = COS_HALF[fold_idx];
         idx_in   = (idx_next >= (IDX_W + 1)'(ROM_LEN)) ? IDX_W'(idx_next - (IDX_W + 1)'(ROM_LEN))
                                                        : IDX_W'(idx_next);
      end
      if (do_scale) begin
         prod_in          = mul_out;
         dir_in[phase_ff] = !entry_ff[DATA_W-1];
      end
      if (do_period) begin
         duty_in[phase_ff] = mul_out[PROD_W-1:MUL_A_W];
         phase_in          = last_phase ? phase_ff : phase_ff + PHASE_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_duty_a_in = rsp_duty_a_ff;
      rsp_duty_b_in = rsp_duty_b_ff;
      rsp_duty_c_in = rsp_duty_c_ff;
      rsp_dir_a_in  = rsp_dir_a_ff;
      rsp_dir_b_in  = rsp_dir_b_ff;
      rsp_dir_c_in  = rsp_dir_c_ff;
      rsp_step_in   = rsp_step_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_duty_a_in = duty_ff[0];
         rsp_duty_b_in = duty_ff[1];
         rsp_duty_c_in = duty_ff[2];
         rsp_dir_a_in  = dir_ff[0];
         rsp_dir_b_in  = dir_ff[1];
         rsp_dir_c_in  = dir_ff[2];
         rsp_step_in   = OUT_STEP_W'(step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      entry_ff      <= entry_in;
      prod_ff       <= prod_in;
      duty_ff       <= duty_in;
      dir_ff        <= dir_in;
      rsp_duty_a_ff <= rsp_duty_a_in;
      rsp_duty_b_ff <= rsp_duty_b_in;
      rsp_duty_c_ff <= rsp_duty_c_in;
      rsp_dir_a_ff  <= rsp_dir_a_in;
      rsp_dir_b_ff  <= rsp_dir_b_in;
      rsp_dir_c_ff  <= rsp_dir_c_in;
      rsp_step_ff   <= rsp_step_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_duty_a    = rsp_duty_a_ff;
   assign rsp_duty_b    = rsp_duty_b_ff;
   assign rsp_duty_c    = rsp_duty_c_ff;
   assign rsp_dir_a     = rsp_dir_a_ff;
   assign rsp_dir_b     = rsp_dir_b_ff;
   assign rsp_dir_c     = rsp_dir_c_ff;
   assign rsp_step_used = rsp_step_ff;

endmodule

`default_nettype wire

@@ rtl/core/tpsp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpsp_checker
   import tpsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [DATA_W-1:0]     rsp_duty_a,
   input  logic [DATA_W-1:0]     rsp_duty_b,
   input  logic [DATA_W-1:0]     rsp_duty_c,
   input  logic                  rsp_dir_a,
   input  logic                  rsp_dir_b,
   input  logic                  rsp_dir_c,
   input  logic [OUT_STEP_W-1:0] rsp_step_used
);

   localparam logic WRAP_CHECK = (STEPS <= (1 << OUT_STEP_W));

   logic                  rsp_accept;
   logic                  seen_ff;
   logic                  seen_in;
   logic [OUT_STEP_W-1:0] last_step_ff;
   logic [OUT_STEP_W-1:0] last_step_in;
   logic [OUT_STEP_W-1:0] next_step;

   assign rsp_accept = rsp_valid && rsp_ready;
   assign next_step  = (last_step_ff == OUT_STEP_W'(STEPS - 1)) ? '0
                                                                : last_step_ff + OUT_STEP_W'(1);

   always_comb begin
      seen_in      = seen_ff || rsp_accept;
      last_step_in = rsp_accept ? rsp_step_used : last_step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         last_step_ff <= '0;
      end else begin
         seen_ff      <= seen_in;
         last_step_ff <= last_step_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty_a) && $stable(rsp_duty_b)
         && $stable(rsp_duty_c) && $stable(rsp_dir_a) && $stable(rsp_dir_b)
         && $stable(rsp_dir_c) && $stable(rsp_step_used))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_first_step: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !seen_ff |-> rsp_step_used == '0)
      else $error("first update after reset is not at step zero");

   a_step_order: assert property (@(posedge clock) disable iff (reset)
      WRAP_CHECK && rsp_accept && seen_ff |-> rsp_step_used == next_step)
      else $error("update skipped or repeated a step");

endmodule

bind three_phase_sine_pwm_generator_unit tpsp_checker u_tpsp_checker (.*);

`default_nettype wire
